### hw/rtl/scsa_pkg.sv
// Shared types, constants and helpers of the size-class slab allocator.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing else.
package scsa_pkg;

   // Default pool geometry, handed down from the top level.
   localparam int NUM_SLABS_DEF       = 32;
   localparam int CHUNKS_PER_SLAB_DEF = 512;

   // Fixed field widths of the request and response.
   localparam int MODE_W      = 2;
   localparam int SIZE_W      = 8;
   localparam int HANDLE_W    = 14;
   localparam int STATUS_W    = 2;
   localparam int NUM_CLASSES = 8;
   localparam int CLASS_W     = 3;

   localparam logic [SIZE_W-1:0] MAX_REQUEST = 8'd224;

   // Chunk size of each class in bytes.
   localparam logic [SIZE_W-1:0] CLASS_BYTES [NUM_CLASSES] =
      '{8'd8, 8'd16, 8'd24, 8'd32, 8'd48, 8'd64, 8'd120, 8'd224};

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_OOM        = 2'd1,
      ST_BAD_SIZE   = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   // Micro-operations the controller asks of the datapath, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DECODE, OP_SPLIT, OP_RD_CUR, OP_KEEP, OP_RD_AUX,
      OP_BASE, OP_CRD, OP_POP, OP_BUMP, OP_WR_OWN, OP_WALK_INIT, OP_WALK_HIT,
      OP_WALK_NEXT, OP_POOL_INIT, OP_POOL_HIT, OP_POOL_NEXT, OP_LF_WR,
      OP_WR_PREV_CUR, OP_CUR_OPEN, OP_ST_OOM, OP_ST_BADH, OP_QRESP, OP_DEC,
      OP_PUSH, OP_UL_P, OP_WR_NEXT_OWN, OP_UL_N, OP_WR_PREV_OWN, OP_RELEASE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   // Flags the datapath reports back, all taken from registers.
   typedef struct packed {
      logic mode_alloc;
      logic mode_free;
      logic mode_query;
      logic req_bad;
      logic cur_ok;
      logic own_full;
      logic own_has_freed;
      logic own_can_bump;
      logic own_used;
      logic own_free_bad;
      logic own_empty_linked;
      logic own_prev_ok;
      logic own_next_ok;
      logic aux_ok;
      logic walk_more;
      logic rec_open;
      logic rec_used;
      logic aux_last;
   } stat_type;

   // Smallest class that holds the requested size.
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] c;
      c = CLASS_W'(NUM_CLASSES - 1);
      for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
         if (size <= CLASS_BYTES[i]) begin
            c = CLASS_W'(i);
         end
      end
      return c;
   endfunction

endpackage

### hw/rtl/size_class_slab_allocator.sv
// Sequence: a request is loaded, decoded and split; a bad size or handle then goes to the
// response, a query or free reads the slab record, and an alloc takes a chunk by bump or from
// the freed list. A slab that fills or empties adds a walk of the class list, a pool scan, and
// unlinking and relinking, all through one read and one write port of the slab records.
// Throughput: one request in flight; the next is taken the cycle after the response transfer.
// Reset is synchronous; slab records read as reset values through per-slab valid bits.
module size_class_slab_allocator
   import scsa_pkg::*;
#(
   parameter int NUM_SLABS       = NUM_SLABS_DEF,
   parameter int CHUNKS_PER_SLAB = CHUNKS_PER_SLAB_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // request_size[7:0], chunk_handle[21:8], zero
   input  logic [1:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // granted_handle[13:0], chunk_size[21:14], zero
   output logic [1:0]  rsp_tuser   // status
);

   cmd_type             cmd;
   stat_type            st;
   logic [HANDLE_W-1:0] granted_handle;
   logic [SIZE_W-1:0]   chunk_size;

   // Sequencer.
   scsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   scsa_dp #(
      .NUM_SLABS       (NUM_SLABS),
      .CHUNKS_PER_SLAB (CHUNKS_PER_SLAB)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_tuser),
      .req_request_size   (req_tdata[7:0]),
      .req_chunk_handle   (req_tdata[21:8]),
      .st                 (st),
      .rsp_granted_handle (granted_handle),
      .rsp_chunk_size     (chunk_size),
      .rsp_status         (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, chunk_size, granted_handle};

endmodule

### hw/rtl/scsa_ctrl.sv
// Sequencing state machine of the slab allocator.
// Issues one datapath micro-operation per cycle; depends on scsa_pkg.
module scsa_ctrl
   import scsa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [34:0] {
      S_IDLE    = 35'd1 << 0,  S_DECODE  = 35'd1 << 1,  S_SPLIT   = 35'd1 << 2,
      S_RD_CUR  = 35'd1 << 3,  S_KEEP    = 35'd1 << 4,  S_A_CHECK = 35'd1 << 5,
      S_A_BASE  = 35'd1 << 6,  S_A_CRD   = 35'd1 << 7,  S_A_POP   = 35'd1 << 8,
      S_A_BUMP  = 35'd1 << 9,  S_A_WR    = 35'd1 << 10, S_W_INIT  = 35'd1 << 11,
      S_W_TEST  = 35'd1 << 12, S_W_RD    = 35'd1 << 13, S_W_CHK   = 35'd1 << 14,
      S_P_INIT  = 35'd1 << 15, S_P_RD    = 35'd1 << 16, S_P_CHK   = 35'd1 << 17,
      S_LF_WR   = 35'd1 << 18, S_LF_TEST = 35'd1 << 19, S_LF_RD   = 35'd1 << 20,
      S_LF_PREV = 35'd1 << 21, S_A_RETRY = 35'd1 << 22, S_OOM     = 35'd1 << 23,
      S_F_CHECK = 35'd1 << 24, S_F_SPLIT = 35'd1 << 25, S_F_PUSH  = 35'd1 << 26,
      S_UL_P    = 35'd1 << 27, S_UL_PRD  = 35'd1 << 28, S_UL_PWR  = 35'd1 << 29,
      S_UL_N    = 35'd1 << 30, S_UL_NRD  = 35'd1 << 31, S_UL_NWR  = 35'd1 << 32,
      S_RELEASE = 35'd1 << 33, S_RESP    = 35'd1 << 34
   } state_type;

   state_type state_ff, state_in, lf_done;
   // Set while refilling after an allocation filled its slab.
   logic      ret_ff, ret_in;
   logic      mode_none;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign mode_none  = !(st.mode_alloc || st.mode_free || st.mode_query);
   assign lf_done    = (st.mode_alloc && !ret_ff) ? S_A_RETRY : S_RESP;

   // Next state and micro-operation.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op   = OP_DECODE;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = (mode_none || st.req_bad) ? S_RESP : S_RD_CUR;
         end
         S_RD_CUR: begin
            cmd.op   = OP_RD_CUR;
            state_in = S_KEEP;
         end
         S_KEEP: begin
            cmd.op   = OP_KEEP;
            state_in = st.mode_alloc ? S_A_CHECK : S_F_CHECK;
         end
         S_A_CHECK: begin
            if (!st.cur_ok || st.own_full) begin
               ret_in   = 1'b0;
               state_in = S_W_INIT;
            end else if (st.own_has_freed || st.own_can_bump) begin
               state_in = S_A_BASE;
            end else begin
               state_in = S_OOM;
            end
         end
         S_A_BASE: begin
            cmd.op   = OP_BASE;
            state_in = st.own_has_freed ? S_A_CRD : S_A_BUMP;
         end
         S_A_CRD: begin
            cmd.op   = OP_CRD;
            state_in = S_A_POP;
         end
         S_A_POP: begin
            cmd.op   = OP_POP;
            state_in = S_A_WR;
         end
         S_A_BUMP: begin
            cmd.op   = OP_BUMP;
            state_in = S_A_WR;
         end
         S_A_WR: begin
            cmd.op = OP_WR_OWN;
            if (st.own_full) begin
               ret_in   = 1'b1;
               state_in = S_W_INIT;
            end else begin
               state_in = S_RESP;
            end
         end
         // Walk of the class list for a slab that is not full.
         S_W_INIT: begin
            cmd.op   = OP_WALK_INIT;
            state_in = S_W_TEST;
         end
         S_W_TEST: begin
            if (st.walk_more) begin
               state_in = S_W_RD;
            end else begin
               state_in = st.mode_alloc ? S_P_INIT : S_LF_WR;
            end
         end
         S_W_RD: begin
            cmd.op   = OP_RD_AUX;
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            if (st.rec_open) begin
               cmd.op = OP_WALK_HIT;
               if (!st.mode_alloc) begin
                  state_in = S_RELEASE;
               end else begin
                  state_in = ret_ff ? S_RESP : S_A_RETRY;
               end
            end else begin
               cmd.op   = OP_WALK_NEXT;
               state_in = S_W_TEST;
            end
         end
         // Scan of the pool for the lowest unused slab.
         S_P_INIT: begin
            cmd.op   = OP_POOL_INIT;
            state_in = S_P_RD;
         end
         S_P_RD: begin
            cmd.op   = OP_RD_AUX;
            state_in = S_P_CHK;
         end
         S_P_CHK: begin
            if (!st.rec_used) begin
               cmd.op   = OP_POOL_HIT;
               state_in = S_LF_WR;
            end else if (st.aux_last) begin
               state_in = ret_ff ? S_RESP : S_OOM;
            end else begin
               cmd.op   = OP_POOL_NEXT;
               state_in = S_P_RD;
            end
         end
         // Link a fresh slab at the head of the class.
         S_LF_WR: begin
            cmd.op   = OP_LF_WR;
            state_in = S_LF_TEST;
         end
         S_LF_TEST: begin
            state_in = st.aux_ok ? S_LF_RD : lf_done;
         end
         S_LF_RD: begin
            cmd.op   = OP_RD_AUX;
            state_in = S_LF_PREV;
         end
         S_LF_PREV: begin
            cmd.op   = OP_WR_PREV_CUR;
            state_in = lf_done;
         end
         S_A_RETRY: begin
            cmd.op   = OP_CUR_OPEN;
            state_in = S_RD_CUR;
         end
         S_OOM: begin
            cmd.op   = OP_ST_OOM;
            state_in = S_RESP;
         end
         // Free and query checks.
         S_F_CHECK: begin
            if (!st.own_used) begin
               cmd.op   = OP_ST_BADH;
               state_in = S_RESP;
            end else if (st.mode_query) begin
               cmd.op   = OP_QRESP;
               state_in = S_RESP;
            end else if (st.own_free_bad) begin
               cmd.op   = OP_ST_BADH;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_DEC;
               state_in = S_F_SPLIT;
            end
         end
         S_F_SPLIT: begin
            state_in = st.own_empty_linked ? S_UL_P : S_F_PUSH;
         end
         S_F_PUSH: begin
            cmd.op   = OP_PUSH;
            state_in = S_RESP;
         end
         // Unlink an emptied slab from its class list.
         S_UL_P: begin
            cmd.op   = OP_UL_P;
            state_in = st.own_prev_ok ? S_UL_PRD : S_UL_N;
         end
         S_UL_PRD: begin
            cmd.op   = OP_RD_AUX;
            state_in = S_UL_PWR;
         end
         S_UL_PWR: begin
            cmd.op   = OP_WR_NEXT_OWN;
            state_in = S_UL_N;
         end
         S_UL_N: begin
            cmd.op   = OP_UL_N;
            state_in = st.own_next_ok ? S_UL_NRD : S_W_INIT;
         end
         S_UL_NRD: begin
            cmd.op   = OP_RD_AUX;
            state_in = S_UL_NWR;
         end
         S_UL_NWR: begin
            cmd.op   = OP_WR_PREV_OWN;
            state_in = S_W_INIT;
         end
         S_RELEASE: begin
            cmd.op   = OP_RELEASE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

### hw/rtl/scsa_dp.sv
// Datapath of the slab allocator: slab record memory, chunk link memory,
// class head and open registers, working registers. Depends on scsa_pkg.
module scsa_dp
   import scsa_pkg::*;
#(
   parameter int NUM_SLABS       = NUM_SLABS_DEF,
   parameter int CHUNKS_PER_SLAB = CHUNKS_PER_SLAB_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [HANDLE_W-1:0] req_chunk_handle,
   output stat_type            st,
   output logic [HANDLE_W-1:0] rsp_granted_handle,
   output logic [SIZE_W-1:0]   rsp_chunk_size,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int SW    = $clog2(NUM_SLABS);
   localparam int LW    = $clog2(NUM_SLABS + 1);
   localparam int NW    = $clog2(NUM_SLABS + 1);
   localparam int CW    = $clog2(CHUNKS_PER_SLAB);
   localparam int CNTW  = $clog2(CHUNKS_PER_SLAB + 1);
   localparam int DEPTH = NUM_SLABS * CHUNKS_PER_SLAB;
   localparam int CAW   = $clog2(DEPTH);
   localparam int MW    = LW + 13;
   // Handle split by reciprocal: exact for any handle of HANDLE_W bits.
   localparam int RSH   = 28;
   localparam logic [HANDLE_W+RSH-1:0] RECIP =
      (HANDLE_W+RSH)'(((64'd1 << RSH) + CHUNKS_PER_SLAB - 1) / CHUNKS_PER_SLAB);
   localparam logic [CNTW-1:0] CPS_C  = CNTW'(CHUNKS_PER_SLAB);
   localparam logic [LW-1:0]   NONE_C = LW'(NUM_SLABS);

   typedef struct packed {
      logic               used;
      logic [CLASS_W-1:0] cls;
      logic [CNTW-1:0]    live;
      logic [CNTW-1:0]    bump;
      logic [CNTW-1:0]    fhead;
      logic [LW-1:0]      next;
      logic [LW-1:0]      prev;
   } rec_type;

   // Record of a slab that was never written.
   function automatic rec_type reset_rec(input logic [SW-1:0] i);
      rec_type r;
      r.used  = (int'(i) < NUM_CLASSES);
      r.cls   = r.used ? CLASS_W'(i) : '0;
      r.live  = '0;
      r.bump  = '0;
      r.fhead = CPS_C;
      r.next  = NONE_C;
      r.prev  = NONE_C;
      return r;
   endfunction

   rec_type             slab_mem [NUM_SLABS];
   logic [CNTW-1:0]     chunk_mem [DEPTH];

   mode_type            mode_ff, mode_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [HANDLE_W-1:0] q_ff, q_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       aux_ff, aux_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [CAW-1:0]      base_ff, base_in;
   rec_type             own_ff, own_in;
   logic [LW-1:0]       head_ff [NUM_CLASSES];
   logic [LW-1:0]       head_in [NUM_CLASSES];
   logic [LW-1:0]       open_ff [NUM_CLASSES];
   logic [LW-1:0]       open_in [NUM_CLASSES];
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic [SIZE_W-1:0]   out_size_ff, out_size_in;
   status_type          out_status_ff, out_status_in;
   logic [NUM_SLABS-1:0] vld_ff, vld_in;

   // Memory port signals and registered read data.
   logic                sr_en, sw_en, cw_en, cr_en;
   logic [SW-1:0]       sr_addr, sw_addr;
   rec_type             sw_data, slab_rd_ff, rec_rd;
   logic [SW-1:0]       rd_addr_ff;
   logic                rd_vld_ff;
   logic [CAW-1:0]      cw_addr, cr_addr;
   logic [CNTW-1:0]     chunk_rd_ff;

   logic [HANDLE_W+RSH-1:0] q_prod;
   logic [2*HANDLE_W-1:0]   k_prod;
   logic [MW-1:0]           base_prod;
   logic                    bad_size, q_bad;

   assign q_prod    = (HANDLE_W+RSH)'(handle_ff) * RECIP;
   assign k_prod    = (2*HANDLE_W)'(q_ff) * (2*HANDLE_W)'(CHUNKS_PER_SLAB);
   assign base_prod = MW'(cur_ff) * MW'(CHUNKS_PER_SLAB);
   assign rec_rd    = rd_vld_ff ? slab_rd_ff : reset_rec(rd_addr_ff);
   assign bad_size  = (size_ff == '0) || (size_ff > MAX_REQUEST);
   assign q_bad     = (q_ff >= HANDLE_W'(NUM_SLABS));

   // Status flags for the controller.
   always_comb begin
      st.mode_alloc       = (mode_ff == MODE_ALLOC);
      st.mode_free        = (mode_ff == MODE_FREE);
      st.mode_query       = (mode_ff == MODE_QUERY);
      st.req_bad          = (st.mode_alloc && bad_size) ||
                            ((st.mode_free || st.mode_query) && q_bad);
      st.cur_ok           = (cur_ff < NONE_C);
      st.own_full         = (own_ff.live >= CPS_C);
      st.own_has_freed    = (own_ff.fhead < CPS_C);
      st.own_can_bump     = (own_ff.bump < CPS_C);
      st.own_used         = own_ff.used;
      st.own_free_bad     = (own_ff.live == '0) || (CNTW'(k_ff) >= own_ff.bump);
      st.own_prev_ok      = (own_ff.prev < NONE_C);
      st.own_next_ok      = (own_ff.next < NONE_C);
      st.own_empty_linked = (own_ff.live == '0) && (st.own_prev_ok || st.own_next_ok);
      st.aux_ok           = (aux_ff < NONE_C);
      st.walk_more        = st.aux_ok && (n_ff < NW'(NUM_SLABS));
      st.rec_open         = (rec_rd.live < CPS_C);
      st.rec_used         = rec_rd.used;
      st.aux_last         = (aux_ff == LW'(NUM_SLABS - 1));
   end

   // Register updates and memory requests per micro-operation.
   always_comb begin
      mode_in       = mode_ff;
      size_in       = size_ff;
      handle_in     = handle_ff;
      cls_in        = cls_ff;
      q_in          = q_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      aux_in        = aux_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      own_in        = own_ff;
      head_in       = head_ff;
      open_in       = open_ff;
      out_handle_in = out_handle_ff;
      out_size_in   = out_size_ff;
      out_status_in = out_status_ff;
      vld_in        = vld_ff;
      sr_en         = 1'b0;
      sr_addr       = cur_ff[SW-1:0];
      sw_en         = 1'b0;
      sw_addr       = cur_ff[SW-1:0];
      sw_data       = own_ff;
      cw_en         = 1'b0;
      cw_addr       = CAW'(handle_ff);
      cr_en         = 1'b0;
      cr_addr       = base_ff + CAW'(own_ff.fhead);
      case (cmd.op)
         OP_LOAD: begin
            mode_in       = mode_type'(req_mode);
            size_in       = req_request_size;
            handle_in     = req_chunk_handle;
            out_handle_in = '0;
            out_size_in   = '0;
            out_status_in = ST_OK;
         end
         OP_DECODE: begin
            cls_in = class_of(size_ff);
            q_in   = q_prod[HANDLE_W+RSH-1:RSH];
         end
         OP_SPLIT: begin
            k_in   = CW'(handle_ff - HANDLE_W'(k_prod));
            cur_in = (mode_ff == MODE_ALLOC) ? open_ff[cls_ff] : LW'(q_ff);
            if ((mode_ff == MODE_ALLOC) && bad_size) begin
               out_status_in = ST_BAD_SIZE;
            end
            if (((mode_ff == MODE_FREE) || (mode_ff == MODE_QUERY)) && q_bad) begin
               out_status_in = ST_BAD_HANDLE;
            end
         end
         OP_RD_CUR: begin
            sr_en = 1'b1;
         end
         OP_RD_AUX: begin
            sr_en   = 1'b1;
            sr_addr = aux_ff[SW-1:0];
         end
         OP_KEEP: begin
            own_in = rec_rd;
         end
         OP_BASE: begin
            base_in = CAW'(base_prod);
         end
         OP_CRD: begin
            cr_en = 1'b1;
         end
         OP_POP: begin
            out_handle_in = HANDLE_W'(base_ff + CAW'(own_ff.fhead));
            out_size_in   = CLASS_BYTES[cls_ff];
            own_in.fhead  = chunk_rd_ff;
            own_in.live   = own_ff.live + 1'b1;
         end
         OP_BUMP: begin
            out_handle_in = HANDLE_W'(base_ff + CAW'(own_ff.bump));
            out_size_in   = CLASS_BYTES[cls_ff];
            own_in.bump   = own_ff.bump + 1'b1;
            own_in.live   = own_ff.live + 1'b1;
         end
         OP_WR_OWN: begin
            sw_en = 1'b1;
         end
         OP_WALK_INIT: begin
            aux_in = head_ff[cls_ff];
            n_in   = '0;
         end
         OP_WALK_HIT: begin
            open_in[cls_ff] = aux_ff;
         end
         OP_WALK_NEXT: begin
            aux_in = rec_rd.next;
            n_in   = n_ff + 1'b1;
         end
         OP_POOL_INIT: begin
            aux_in = '0;
         end
         OP_POOL_HIT: begin
            cur_in = aux_ff;
         end
         OP_POOL_NEXT: begin
            aux_in = aux_ff + 1'b1;
         end
         OP_LF_WR: begin
            sw_en           = 1'b1;
            sw_data.used    = 1'b1;
            sw_data.cls     = cls_ff;
            sw_data.live    = '0;
            sw_data.bump    = '0;
            sw_data.fhead   = CPS_C;
            sw_data.next    = head_ff[cls_ff];
            sw_data.prev    = NONE_C;
            aux_in          = head_ff[cls_ff];
            head_in[cls_ff] = cur_ff;
            open_in[cls_ff] = cur_ff;
         end
         OP_WR_PREV_CUR: begin
            sw_en        = 1'b1;
            sw_addr      = aux_ff[SW-1:0];
            sw_data      = rec_rd;
            sw_data.prev = cur_ff;
         end
         OP_CUR_OPEN: begin
            cur_in = open_ff[cls_ff];
         end
         OP_ST_OOM: begin
            out_status_in = ST_OOM;
         end
         OP_ST_BADH: begin
            out_status_in = ST_BAD_HANDLE;
         end
         OP_QRESP: begin
            out_size_in = CLASS_BYTES[own_ff.cls];
         end
         OP_DEC: begin
            own_in.live = own_ff.live - 1'b1;
            cls_in      = own_ff.cls;
         end
         OP_PUSH: begin
            cw_en         = 1'b1;
            sw_en         = 1'b1;
            sw_data.fhead = CNTW'(k_ff);
         end
         OP_UL_P: begin
            aux_in = own_ff.prev;
            if (!(own_ff.prev < NONE_C)) begin
               head_in[cls_ff] = own_ff.next;
            end
         end
         OP_WR_NEXT_OWN: begin
            sw_en        = 1'b1;
            sw_addr      = aux_ff[SW-1:0];
            sw_data      = rec_rd;
            sw_data.next = own_ff.next;
         end
         OP_UL_N: begin
            aux_in = own_ff.next;
         end
         OP_WR_PREV_OWN: begin
            sw_en        = 1'b1;
            sw_addr      = aux_ff[SW-1:0];
            sw_data      = rec_rd;
            sw_data.prev = own_ff.prev;
         end
         OP_RELEASE: begin
            sw_en        = 1'b1;
            sw_data.used = 1'b0;
            sw_data.next = NONE_C;
            sw_data.prev = NONE_C;
         end
         default: begin
         end
      endcase
      if (sw_en) begin
         vld_in[sw_addr] = 1'b1;
      end
   end

   // Slab records: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (sw_en) begin
         slab_mem[sw_addr] <= sw_data;
      end
      if (sr_en) begin
         slab_rd_ff <= slab_mem[sr_addr];
         rd_addr_ff <= sr_addr;
         rd_vld_ff  <= vld_ff[sr_addr];
      end
   end

   // Chunk link memory, left unset until a free writes an entry.
   always_ff @(posedge clock) begin
      if (cw_en) begin
         chunk_mem[cw_addr] <= own_ff.fhead;
      end
      if (cr_en) begin
         chunk_rd_ff <= chunk_mem[cr_addr];
      end
   end

   // Control state: slab valid bits, class heads and open slabs; payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= LW'(i);
            open_ff[i] <= LW'(i);
         end
      end else begin
         vld_ff  <= vld_in;
         head_ff <= head_in;
         open_ff <= open_in;
      end
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      handle_ff     <= handle_in;
      cls_ff        <= cls_in;
      q_ff          <= q_in;
      k_ff          <= k_in;
      cur_ff        <= cur_in;
      aux_ff        <= aux_in;
      n_ff          <= n_in;
      base_ff       <= base_in;
      own_ff        <= own_in;
      out_handle_ff <= out_handle_in;
      out_size_ff   <= out_size_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_granted_handle = out_handle_ff;
   assign rsp_chunk_size     = out_size_ff;
   assign rsp_status         = out_status_ff;

endmodule

### hw/rtl/scsa_checker.sv
// Port-level checks of the slab allocator over time, bound to the top level.
// Depends on scsa_pkg and size_class_slab_allocator.
module scsa_checker
   import scsa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Only one request is in flight: no new transfer while a response waits.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // A request never answers in the cycle after its transfer.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response too early");

   // An error response carries no handle and no size.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == 24'd0))
      else $error("error response with data");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (.*);
